// File: rtl/pkm_pkg.sv
// Package for the packet keyword matcher.
// Holds field widths, configuration register indexes, the cell control
// struct and the keyword byte select function. No dependencies.
package pkm_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KEY_REG_W = 64;
  localparam int unsigned KEY_LEN_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned COUNT_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } pkm_cfg_idx_t;

  typedef struct packed {
    logic shift;   // move the window one place this cycle
    logic active;  // cell lies inside the keyword length
  } pkm_cell_ctrl_t;

  // Byte j of the 16-byte keyword, low register holds bytes 0 to 7.
  function automatic logic [BYTE_W-1:0] pick_key_byte(
    input logic [KEY_REG_W-1:0] key_lo,
    input logic [KEY_REG_W-1:0] key_hi,
    input logic [3:0]           j
  );
    logic [KEY_REG_W-1:0] word;
    word = j[3] ? key_hi : key_lo;
    return word[{j[2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

// File: rtl/pkm_cell.sv
// One window cell of the keyword matcher: holds a byte, passes it to the
// next cell on each shift and compares the incoming byte with its keyword byte.
// Depends on pkm_pkg.
module pkm_cell import pkm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pkm_cell_ctrl_t    ctrl,
  input  logic [BYTE_W-1:0] shift_in,
  input  logic [BYTE_W-1:0] key_byte,
  output logic [BYTE_W-1:0] byte_out,
  output logic              match
);

  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (ctrl.shift) begin
      byte_r <= shift_in;
    end
  end

  assign byte_out = byte_r;
  // compare the value the cell takes on this shift; idle cells never block
  assign match    = !ctrl.active || (shift_in == key_byte);

endmodule

// File: rtl/packet_keyword_matcher.sv
// Packet keyword matcher: one packet byte per cycle, back to back, except that
// the last byte of a packet waits while the output register is full and stalled.
// The result enters the output register in the cycle after that byte is taken;
// cells check each byte in the cycle it arrives, so the rate holds for any key length.
// Synchronous active-low reset clears window, counters, match state and
// the keyword registers; no clearing pass is needed.
module packet_keyword_matcher import pkm_pkg::*; #(
  parameter int unsigned MAX_KEY    = 16,
  parameter int unsigned MAX_PACKET = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_REG_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_packet_byte,
  input  logic                 in_end_of_packet,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COUNT_W-1:0]   out_packet_number,
  output logic                 out_found,
  output logic [OFFSET_W-1:0]  out_match_offset
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET + 1);

  logic [KEY_REG_W-1:0] key_lo_r, key_hi_r;
  logic [KEY_LEN_W-1:0] key_len_r;
  logic [KEY_LEN_W-1:0] len_used;

  logic [POS_W-1:0]    pos_r, pos_plus;
  logic                seen_r, seen_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_number_r;
  logic                out_found_r;
  logic [OFFSET_W-1:0] out_offset_r;

  logic                in_xfer, in_range, shift, hit;
  logic [MAX_KEY-1:0]  match_vec;
  logic [BYTE_W-1:0]   win [MAX_KEY];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_lo_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_hi_r  <= cfg_wdata;
        CFG_KEY_LEN:  key_len_r <= cfg_wdata[KEY_LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  assign len_used = (key_len_r > KEY_LEN_W'(MAX_KEY)) ? KEY_LEN_W'(MAX_KEY) : key_len_r;

  // only the last byte of a packet needs room in the output register
  assign in_stall = out_valid_r && out_stall && in_end_of_packet;
  assign in_xfer  = in_valid && !in_stall;
  assign in_range = (pos_r < POS_W'(MAX_PACKET));
  assign shift    = in_xfer && in_range;
  assign pos_plus = pos_r + POS_W'(1);

  for (genvar i = 0; i < MAX_KEY; i++) begin : g_cell
    pkm_cell_ctrl_t       ctrl;
    logic [KEY_LEN_W-1:0] kidx;
    logic [BYTE_W-1:0]    kbyte;
    logic [BYTE_W-1:0]    din;

    assign kidx        = len_used - KEY_LEN_W'(1) - KEY_LEN_W'(i);
    assign kbyte       = pick_key_byte(key_lo_r, key_hi_r, kidx[3:0]);
    assign ctrl.shift  = shift;
    assign ctrl.active = (KEY_LEN_W'(i) < len_used);
    if (i == 0) begin : g_head
      assign din = in_packet_byte;
    end else begin : g_body
      assign din = win[i-1];
    end

    pkm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .shift_in (din),
      .key_byte (kbyte),
      .byte_out (win[i]),
      .match    (match_vec[i])
    );
  end

  assign hit = shift && (len_used != '0) && !seen_r
            && (pos_plus >= POS_W'(len_used)) && (&match_vec);

  always_comb begin
    seen_nxt  = seen_r;
    off_nxt   = off_r;
    count_nxt = count_r + COUNT_W'(1);
    if (hit) begin
      seen_nxt = 1'b1;
      off_nxt  = OFFSET_W'(pos_plus - POS_W'(len_used));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      seen_r  <= 1'b0;
      off_r   <= '0;
      count_r <= '0;
    end else if (in_xfer) begin
      if (in_end_of_packet) begin
        pos_r   <= '0;
        seen_r  <= 1'b0;
        off_r   <= '0;
        count_r <= count_nxt;
      end else begin
        if (shift) begin
          pos_r <= pos_plus;
        end
        seen_r <= seen_nxt;
        off_r  <= off_nxt;
      end
    end
  end

  // output register: load on the last byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_end_of_packet) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_end_of_packet) begin
      out_number_r <= count_nxt;
      out_found_r  <= (len_used == '0) || seen_nxt;
      out_offset_r <= (len_used == '0 || !seen_nxt) ? '0 : off_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_number = out_number_r;
  assign out_found         = out_found_r;
  assign out_match_offset  = out_offset_r;

  a_offset_zero_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r || out_offset_r == '0))
    else $error("offset set without a match");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_PACKET))
    else $error("byte position past packet limit");

  a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_end_of_packet) |=> (pos_r == '0 && !seen_r && out_valid_r))
    else $error("packet end did not clear state or load result");

  a_seen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r && !(in_xfer && in_end_of_packet)) |=> (seen_r && $stable(off_r)))
    else $error("first match offset changed within a packet");

endmodule
